>>> hdl/mpl_pkg.sv
// mpl_pkg: shared types and constants for the monotone path length block
// holds the csr register index codes, default sizes and the result struct
// used by mpl_len_calc, mpl_rsp_skid and monotone_path_length_dp
package mpl_pkg;

   // fixed field widths
   localparam int LEN_W      = 11;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 1;

   // parameter defaults
   localparam int DEF_MAX_COLS    = 1024;
   localparam int DEF_MAX_ROWS    = 1024;
   localparam int DEF_VALUE_WIDTH = 16;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] RST_NUM_COLS = 11'd1024;
   localparam logic [CSR_DATA_W-1:0] RST_NUM_ROWS = 11'd1024;

   // saturation limit for path lengths
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // csr register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_COLS = 1'b0,
      CSR_NUM_ROWS = 1'b1
   } csr_index_type;

   // one result transaction
   typedef struct packed {
      logic [LEN_W-1:0] path_length;
      logic [LEN_W-1:0] best_length;
      logic             matrix_done;
   } rsp_type;

endpackage

>>> hdl/mpl_ram.sv
// mpl_ram: generic simple dual port ram, one write and one registered read
// no dependencies; read during write to the same address returns old data
module mpl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/mpl_len_calc.sv
// mpl_len_calc: path length of one cell from its upper and left neighbors
// uses mpl_pkg for the length width and saturation limit
module mpl_len_calc #(
   parameter int VALUE_WIDTH = mpl_pkg::DEF_VALUE_WIDTH
) (
   input  logic signed [VALUE_WIDTH-1:0]  cur_value,
   input  logic signed [VALUE_WIDTH-1:0]  up_value,
   input  logic [mpl_pkg::LEN_W-1:0]      up_length,
   input  logic signed [VALUE_WIDTH-1:0]  left_value,
   input  logic [mpl_pkg::LEN_W-1:0]      left_length,
   input  logic                           has_up,
   input  logic                           has_left,
   output logic [mpl_pkg::LEN_W-1:0]      path_length
);

   logic                        gt_up;
   logic                        gt_left;
   logic [mpl_pkg::LEN_W-1:0]   base_len;

   assign gt_up   = has_up && (cur_value > up_value);
   assign gt_left = has_left && (cur_value > left_value);

   always_comb begin
      base_len = '0;
      if (gt_up && gt_left) begin
         base_len = (up_length > left_length) ? up_length : left_length;
      end else if (gt_up) begin
         base_len = up_length;
      end else if (gt_left) begin
         base_len = left_length;
      end
      // saturating increment, an isolated cell gives base 0 and length 1
      if (base_len == mpl_pkg::LEN_MAX) begin
         path_length = mpl_pkg::LEN_MAX;
      end else begin
         path_length = base_len + mpl_pkg::LEN_W'(1);
      end
   end

endmodule

>>> hdl/mpl_rsp_skid.sv
// mpl_rsp_skid: two entry output register with skid stage for results
// uses mpl_pkg::rsp_type; upstream stall is registered
module mpl_rsp_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_push,
   input  mpl_pkg::rsp_type in_data,
   output logic             in_stall,
   output logic             out_valid,
   output mpl_pkg::rsp_type out_data,
   input  logic             out_stall
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   mpl_pkg::rsp_type main_ff, main_in;
   mpl_pkg::rsp_type skid_ff, skid_in;
   logic             pop;

   assign pop = main_valid_ff && !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_push) begin
         if (!main_valid_ff || pop) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

>>> hdl/monotone_path_length_dp.sv
// monotone_path_length_dp: top level, longest increasing down/right path per cell
// results are registered in the output or skid stage; rsp_stall backs up to req_stall
// throughput: one per cycle when unstalled, set by left neighbor loop (compare, max, +1)
// reset: synchronous, clears position, running best, left cell and the output stages;
//   csr registers return to 1024 columns and 1024 rows; line stores are not cleared
// depends on mpl_pkg, mpl_ram, mpl_len_calc, mpl_rsp_skid
module monotone_path_length_dp #(
   parameter int MAX_COLS    = mpl_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS    = mpl_pkg::DEF_MAX_ROWS,
   parameter int VALUE_WIDTH = mpl_pkg::DEF_VALUE_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   // input transactions
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [VALUE_WIDTH-1:0]      req_cell_value,
   // result transactions
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mpl_pkg::LEN_W-1:0]          rsp_path_length,
   output logic [mpl_pkg::LEN_W-1:0]          rsp_best_length,
   output logic                               rsp_matrix_done,
   // configuration writes
   input  logic                               csr_write,
   input  logic [mpl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mpl_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   // compare width holds col+1, row+1, the bounds and the raw csr values
   localparam int CMP_A = (COL_W > ROW_W) ? COL_W + 1 : ROW_W + 1;
   localparam int CMP_W = (CMP_A > mpl_pkg::CSR_DATA_W) ? CMP_A : mpl_pkg::CSR_DATA_W;
   localparam logic [CMP_W-1:0] MAX_COLS_C = CMP_W'(MAX_COLS);
   localparam logic [CMP_W-1:0] MAX_ROWS_C = CMP_W'(MAX_ROWS);
   localparam logic [CMP_W-1:0] ONE_C      = CMP_W'(1);

   // csr registers
   logic [mpl_pkg::CSR_DATA_W-1:0] num_cols_ff, num_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff <= mpl_pkg::RST_NUM_COLS;
         num_rows_ff <= mpl_pkg::RST_NUM_ROWS;
      end else if (csr_write) begin
         unique case (mpl_pkg::csr_index_type'(csr_index))
            mpl_pkg::CSR_NUM_COLS: num_cols_ff <= csr_data;
            mpl_pkg::CSR_NUM_ROWS: num_rows_ff <= csr_data;
         endcase
      end
   end

   // effective bounds: zero acts as one, values above the maximum clamp
   logic [CMP_W-1:0] cols_raw, rows_raw, cols_eff, rows_eff;

   assign cols_raw = CMP_W'(num_cols_ff);
   assign rows_raw = CMP_W'(num_rows_ff);
   assign cols_eff = (cols_raw == '0) ? ONE_C :
                     (cols_raw > MAX_COLS_C) ? MAX_COLS_C : cols_raw;
   assign rows_eff = (rows_raw == '0) ? ONE_C :
                     (rows_raw > MAX_ROWS_C) ? MAX_ROWS_C : rows_raw;

   // position of the next cell, running best and the left neighbor
   logic [COL_W-1:0]                col_ff, col_in;
   logic [ROW_W-1:0]                row_ff, row_in;
   logic [mpl_pkg::LEN_W-1:0]       best_ff, best_in;
   logic signed [VALUE_WIDTH-1:0]   left_value_ff;
   logic [mpl_pkg::LEN_W-1:0]       left_length_ff;

   logic                            accept;
   logic                            row_end, done;
   logic [mpl_pkg::LEN_W-1:0]       cur_len;
   logic [mpl_pkg::LEN_W-1:0]       best_now;

   assign accept  = req_valid && !req_stall;
   assign row_end = (CMP_W'(col_ff) + ONE_C) >= cols_eff;
   assign done    = row_end && ((CMP_W'(row_ff) + ONE_C) >= rows_eff);

   // line stores: previous row's values and lengths, read one cell ahead
   logic signed [VALUE_WIDTH-1:0]   ram_up_value;
   logic [mpl_pkg::LEN_W-1:0]       ram_up_length;
   logic signed [VALUE_WIDTH-1:0]   up_value;
   logic [mpl_pkg::LEN_W-1:0]       up_length;

   // forward a write that lands on the column being prefetched (narrow rows)
   logic                            byp_hit_ff;
   logic signed [VALUE_WIDTH-1:0]   byp_value_ff;
   logic [mpl_pkg::LEN_W-1:0]       byp_length_ff;

   mpl_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (MAX_COLS)
   ) u_up_values (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_cell_value),
      .rd_addr (col_in),
      .rd_data (ram_up_value)
   );

   mpl_ram #(
      .WIDTH (mpl_pkg::LEN_W),
      .DEPTH (MAX_COLS)
   ) u_up_lengths (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (cur_len),
      .rd_addr (col_in),
      .rd_data (ram_up_length)
   );

   assign up_value  = byp_hit_ff ? byp_value_ff  : ram_up_value;
   assign up_length = byp_hit_ff ? byp_length_ff : ram_up_length;

   // length of the current cell
   mpl_len_calc #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_len_calc (
      .cur_value   (req_cell_value),
      .up_value    (up_value),
      .up_length   (up_length),
      .left_value  (left_value_ff),
      .left_length (left_length_ff),
      .has_up      (row_ff != '0),
      .has_left    (col_ff != '0),
      .path_length (cur_len)
   );

   assign best_now = (cur_len > best_ff) ? cur_len : best_ff;

   // next position and best
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      best_in = best_ff;
      if (accept) begin
         if (done) begin
            col_in  = '0;
            row_in  = '0;
            best_in = '0;
         end else if (row_end) begin
            col_in  = '0;
            row_in  = row_ff + ROW_W'(1);
            best_in = best_now;
         end else begin
            col_in  = col_ff + COL_W'(1);
            best_in = best_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         best_ff        <= '0;
         left_value_ff  <= '0;
         left_length_ff <= '0;
         byp_hit_ff     <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         best_ff    <= best_in;
         byp_hit_ff <= accept && (col_ff == col_in);
         if (accept) begin
            left_value_ff  <= req_cell_value;
            left_length_ff <= cur_len;
         end
      end
      byp_value_ff  <= req_cell_value;
      byp_length_ff <= cur_len;
   end

   // result register with skid stage
   mpl_pkg::rsp_type rsp_new, rsp_out;

   assign rsp_new.path_length = cur_len;
   assign rsp_new.best_length = best_now;
   assign rsp_new.matrix_done = done;

   mpl_rsp_skid u_rsp_skid (
      .clock     (clock),
      .reset     (reset),
      .in_push   (accept),
      .in_data   (rsp_new),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_out),
      .out_stall (rsp_stall)
   );

   assign rsp_path_length = rsp_out.path_length;
   assign rsp_best_length = rsp_out.best_length;
   assign rsp_matrix_done = rsp_out.matrix_done;

   // the last cell of a matrix clears position and best
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      accept && done |=> (col_ff == '0) && (row_ff == '0) && (best_ff == '0))
      else $error("position or best not cleared after matrix end");

   // a held input always means a result is waiting on the output
   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // a shown result has a nonzero length no larger than its running best
   a_rsp_best: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_path_length != '0) && (rsp_best_length >= rsp_path_length))
      else $error("result length inconsistent with running best");

endmodule
